// ----- sv/mpsd_pkg.sv -----
// shared types and constants for the multi-point spike discriminator
// no dependencies

package mpsd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int TIME_W    = 32;
	localparam int WORD_W    = 23;
	localparam int COUNT_W   = 3;
	localparam int INDEX_W   = 3;
	localparam int OFFSET_W  = 6;
	localparam int AGE_W     = 7;
	localparam int WORD_SLOTS = 4;
	localparam int AGE_LIMIT = 64;

	typedef enum logic [INDEX_W-1:0] {
		REG_DOT_COUNT  = 3'd0,
		REG_DOT_WORD_0 = 3'd1,
		REG_DOT_WORD_1 = 3'd2,
		REG_DOT_WORD_2 = 3'd3,
		REG_DOT_WORD_3 = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] offset;
		logic                       above;
		logic signed [SAMPLE_W-1:0] threshold;
	} dot_t;

endpackage

// ----- sv/mpsd_cell.sv -----
// one history cell: holds one sample and passes it to the next cell on shift
// uses mpsd_pkg

module mpsd_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift,
	input  logic                                clear,
	input  logic signed [mpsd_pkg::SAMPLE_W-1:0] d,
	output logic signed [mpsd_pkg::SAMPLE_W-1:0] q
);

	logic signed [mpsd_pkg::SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= clear ? '0 : d;
		end
	end

	assign q = sample_q;

endmodule

// ----- sv/mpsd_dot.sv -----
// one dot test: picks the history tap at the dot's age and compares to its threshold
// uses mpsd_pkg

module mpsd_dot #(
	parameter int TAPS = 64
) (
	input  mpsd_pkg::dot_t                       dot,
	input  logic signed [mpsd_pkg::AGE_W-1:0]    late,
	input  logic signed [mpsd_pkg::SAMPLE_W-1:0] taps [TAPS],
	output logic                                 ok
);

	logic signed [mpsd_pkg::AGE_W-1:0]    age;
	logic signed [mpsd_pkg::SAMPLE_W-1:0] tap;

	always_comb begin
		age = late - mpsd_pkg::AGE_W'(dot.offset);
		tap = '0;
		for (int k = 0; k < TAPS; k++) begin
			if (age == mpsd_pkg::AGE_W'(k)) begin
				tap = taps[k];
			end
		end
		if (dot.above) begin
			ok = tap > dot.threshold;
		end else begin
			ok = tap < dot.threshold;
		end
	end

endmodule

// ----- sv/multi_point_spike_discriminator.sv -----
// top level of the multi-point spike discriminator: config registers, history chain,
// dot tests, run tracking and output register
// uses mpsd_pkg, mpsd_cell, mpsd_dot
//
// Usage:
//   input channel: sample and first_sample with in_valid / in_stall; an item is taken
//   on a rising edge with in_valid high and in_stall low. first_sample starts a new
//   record (index, history and run cleared, this sample is sample 0).
//   output channel: event_time with out_valid / out_stall, at most one item per input.
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, writes to unknown indexes are dropped.
// Timing:
//   one item per cycle while in_stall is low. The sample shifts into the history chain
//   at acceptance, the dot tests and run update are made from the test stage register,
//   and an event enters the output register as the sample ending its run leaves that stage.
//   While an event waits in the output register under out_stall the test stage
//   cannot move: an item in it holds and in_stall stays high until the event is taken.
// Reset:
//   arst_n clears history, index, run, registers and all valid flags.

module multi_point_spike_discriminator #(
	parameter int HISTORY_DEPTH = 64,
	parameter int MAX_DOTS      = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [mpsd_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 first_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mpsd_pkg::TIME_W-1:0]          event_time,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mpsd_pkg::INDEX_W-1:0]         cfg_index,
	input  logic [mpsd_pkg::WORD_W-1:0]          cfg_data
);

	localparam int TAPS = (HISTORY_DEPTH < mpsd_pkg::AGE_LIMIT) ?
		HISTORY_DEPTH : mpsd_pkg::AGE_LIMIT;
	localparam int NDOT = (MAX_DOTS < mpsd_pkg::WORD_SLOTS) ?
		MAX_DOTS : mpsd_pkg::WORD_SLOTS;

	// config registers
	logic [mpsd_pkg::COUNT_W-1:0] dot_count_q;
	mpsd_pkg::dot_t               dot_q [mpsd_pkg::WORD_SLOTS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_count_q <= '0;
			for (int j = 0; j < mpsd_pkg::WORD_SLOTS; j++) begin
				dot_q[j] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (mpsd_pkg::reg_index_t'(cfg_index))
				mpsd_pkg::REG_DOT_COUNT:  dot_count_q <= cfg_data[mpsd_pkg::COUNT_W-1:0];
				mpsd_pkg::REG_DOT_WORD_0: dot_q[0] <= mpsd_pkg::dot_t'(cfg_data);
				mpsd_pkg::REG_DOT_WORD_1: dot_q[1] <= mpsd_pkg::dot_t'(cfg_data);
				mpsd_pkg::REG_DOT_WORD_2: dot_q[2] <= mpsd_pkg::dot_t'(cfg_data);
				mpsd_pkg::REG_DOT_WORD_3: dot_q[3] <= mpsd_pkg::dot_t'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// handshake and stage control
	logic                        valid_s1;
	logic                        first_s1;
	logic [mpsd_pkg::TIME_W-1:0] n_s1;
	logic                        out_valid_q;
	logic [mpsd_pkg::TIME_W-1:0] event_time_q;
	logic [mpsd_pkg::TIME_W-1:0] index_q;
	logic [mpsd_pkg::TIME_W-1:0] run_q;
	logic                        out_free;
	logic                        s1_go;
	logic                        accept;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// history chain
	logic signed [mpsd_pkg::SAMPLE_W-1:0] hist [TAPS];

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		if (k == 0) begin : g_head
			mpsd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (accept),
				.clear  (1'b0),
				.d      (sample),
				.q      (hist[k])
			);
		end else begin : g_body
			mpsd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (accept),
				.clear  (first_sample),
				.d      (hist[k-1]),
				.q      (hist[k])
			);
		end
	end

	logic signed [mpsd_pkg::SAMPLE_W-1:0] taps [TAPS];

	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			taps[k] = hist[k];
		end
	end

	// window span from the active dots
	logic [mpsd_pkg::COUNT_W-1:0]        active;
	logic signed [mpsd_pkg::AGE_W-1:0]   early;
	logic signed [mpsd_pkg::AGE_W-1:0]   late;
	logic signed [mpsd_pkg::AGE_W-1:0]   off;
	logic [mpsd_pkg::AGE_W-1:0]          span;
	logic [NDOT-1:0]                     dot_ok;
	logic                                match;

	always_comb begin
		active = (dot_count_q > mpsd_pkg::COUNT_W'(NDOT)) ?
			mpsd_pkg::COUNT_W'(NDOT) : dot_count_q;
		early = '0;
		late  = '0;
		for (int j = 0; j < NDOT; j++) begin
			off = mpsd_pkg::AGE_W'(dot_q[j].offset);
			if (mpsd_pkg::COUNT_W'(j) < active) begin
				if (off < early) early = off;
				if (off > late) late = off;
			end
		end
		span = late - early;
	end

	for (genvar j = 0; j < NDOT; j++) begin : g_dot
		mpsd_dot #(
			.TAPS (TAPS)
		) u_dot (
			.dot  (dot_q[j]),
			.late (late),
			.taps (taps),
			.ok   (dot_ok[j])
		);
	end

	always_comb begin
		match = 1'b1;
		for (int j = 0; j < NDOT; j++) begin
			if (mpsd_pkg::COUNT_W'(j) < active && !dot_ok[j]) match = 1'b0;
		end
	end

	// run tracking
	logic [mpsd_pkg::TIME_W-1:0] run_base;
	logic [mpsd_pkg::TIME_W-1:0] pos;
	logic                        testable;
	logic                        emit;

	assign run_base = first_s1 ? '0 : run_q;
	assign testable = n_s1 >= mpsd_pkg::TIME_W'(span);
	assign pos      = n_s1 - mpsd_pkg::TIME_W'(late[mpsd_pkg::AGE_W-2:0]);
	assign emit     = testable && !match && (run_base != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			first_s1    <= 1'b0;
			index_q     <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				first_s1 <= first_sample;
				index_q  <= (first_sample ? '0 : index_q) + mpsd_pkg::TIME_W'(1);
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				if (!testable) begin
					run_q <= run_base;
				end else if (!match) begin
					run_q <= '0;
				end else if (run_base != '1) begin
					run_q <= run_base + mpsd_pkg::TIME_W'(1);
				end else begin
					run_q <= run_base;
				end
			end
			if (s1_go && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_s1 <= first_sample ? '0 : index_q;
		end
		if (s1_go && emit) begin
			event_time_q <= pos - (run_base >> 1);
		end
	end

	assign out_valid  = out_valid_q;
	assign event_time = event_time_q;

	// checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty test stage");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(n_s1) && $stable(first_s1)))
		else $error("held test stage changed");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && emit) |=> (run_q == '0))
		else $error("run not cleared after event");

	a_record_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && first_sample) |=> (index_q == mpsd_pkg::TIME_W'(1) && n_s1 == '0))
		else $error("record start did not restart index");

endmodule

// ----- test/mpsd_event_checker.sv -----
// event checker for the multi-point spike discriminator: watches the config, sample
// and event channels, predicts event times and compares them in order
// depends on mpsd_pkg

module mpsd_event_checker #(
	parameter int MAX_DOTS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [mpsd_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 first_sample,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [mpsd_pkg::TIME_W-1:0]          event_time,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [mpsd_pkg::INDEX_W-1:0]         cfg_index,
	input  logic [mpsd_pkg::WORD_W-1:0]          cfg_data,
	output int                                   errors,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [mpsd_pkg::SAMPLE_W-1:0] history [mpsd_pkg::AGE_LIMIT];
	logic [mpsd_pkg::TIME_W-1:0]          record_pos;
	logic [mpsd_pkg::TIME_W-1:0]          run_len;
	logic [mpsd_pkg::COUNT_W-1:0]         dots_set;
	mpsd_pkg::dot_t                       dots [mpsd_pkg::WORD_SLOTS];
	logic [mpsd_pkg::TIME_W-1:0]          event_times_due [$];
	logic [mpsd_pkg::TIME_W-1:0]          due_time;

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic step_discriminator(input logic signed [mpsd_pkg::SAMPLE_W-1:0] value,
			input logic starts);
		int                                   active;
		int                                   early;
		int                                   late;
		int                                   age;
		logic [mpsd_pkg::TIME_W-1:0]          n;
		logic [mpsd_pkg::TIME_W-1:0]          pos;
		logic signed [mpsd_pkg::SAMPLE_W-1:0] seen;
		bit                                   hit;
		if (starts) begin
			foreach (history[i]) history[i] = '0;
			record_pos = '0;
			run_len = '0;
		end
		n = record_pos;
		record_pos = n + 1;
		for (int i = mpsd_pkg::AGE_LIMIT - 1; i > 0; i--) history[i] = history[i-1];
		history[0] = value;

		active = dots_set;
		if (active > MAX_DOTS) active = MAX_DOTS;
		if (active > mpsd_pkg::WORD_SLOTS) active = mpsd_pkg::WORD_SLOTS;
		early = 0;
		late = 0;
		for (int j = 0; j < active; j++) begin
			if (int'(dots[j].offset) < early) early = int'(dots[j].offset);
			if (int'(dots[j].offset) > late) late = int'(dots[j].offset);
		end
		if (n < mpsd_pkg::TIME_W'(late - early)) return;
		pos = n - mpsd_pkg::TIME_W'(late);

		hit = 1'b1;
		for (int j = 0; j < active && hit; j++) begin
			age = late - int'(dots[j].offset);
			seen = (age < mpsd_pkg::AGE_LIMIT) ? history[age] : '0;
			hit = dots[j].above ? (seen > dots[j].threshold) : (seen < dots[j].threshold);
		end

		if (!hit) begin
			if (run_len != '0) begin
				event_times_due.push_back(pos - (run_len >> 1));
				run_len = '0;
			end
		end else if (run_len != '1) begin
			run_len = run_len + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (history[i]) history[i] = '0;
			foreach (dots[i]) dots[i] = '0;
			record_pos = '0;
			run_len = '0;
			dots_set = '0;
			event_times_due.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (event_times_due.size() == 0) begin
					errors++;
					$display("%0t: event_time expected none, actual %0d", $time, event_time);
				end else begin
					due_time = event_times_due.pop_front();
					if (event_time !== due_time) begin
						errors++;
						$display("%0t: event_time expected %0d, actual %0d",
							$time, due_time, event_time);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mpsd_pkg::REG_DOT_COUNT:  dots_set = cfg_data[mpsd_pkg::COUNT_W-1:0];
					mpsd_pkg::REG_DOT_WORD_0: dots[0] = mpsd_pkg::dot_t'(cfg_data);
					mpsd_pkg::REG_DOT_WORD_1: dots[1] = mpsd_pkg::dot_t'(cfg_data);
					mpsd_pkg::REG_DOT_WORD_2: dots[2] = mpsd_pkg::dot_t'(cfg_data);
					mpsd_pkg::REG_DOT_WORD_3: dots[3] = mpsd_pkg::dot_t'(cfg_data);
					default: ;
				endcase
			end
			if (in_valid && !in_stall) step_discriminator(sample, first_sample);
			pending = event_times_due.size();
		end
	end

endmodule

// ----- test/tb_multi_point_spike_discriminator.sv -----
// testbench top for the multi-point spike discriminator: clock, reset, config writes,
// sample stimulus with idle and stall phases, watchdog and verdict
// depends on mpsd_pkg, multi_point_spike_discriminator and mpsd_event_checker

module tb_multi_point_spike_discriminator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 125;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic signed [mpsd_pkg::SAMPLE_W-1:0] sample = '0;
	logic                                 first_sample = 1'b0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [mpsd_pkg::TIME_W-1:0]          event_time;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [mpsd_pkg::INDEX_W-1:0]         cfg_index = '0;
	logic [mpsd_pkg::WORD_W-1:0]          cfg_data = '0;

	int                                   mismatches;
	int                                   pending;
	int                                   quiet_cycles = 0;
	int                                   sent = 0;
	idle_mode_t                           idle_mode = IDLE_NONE;
	logic [mpsd_pkg::COUNT_W-1:0]         count_now = '0;
	mpsd_pkg::dot_t                       dots_now [mpsd_pkg::WORD_SLOTS];

	always #1 clk = ~clk;

	multi_point_spike_discriminator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.first_sample(first_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_time  (event_time),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	mpsd_event_checker event_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.first_sample(first_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_time  (event_time),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (mismatches),
		.pending     (pending)
	);

	function automatic bit roll(input int percent);
		return $urandom_range(0, 99) < percent;
	endfunction

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return roll(69);
			IDLE_BOTH:   return roll(16);
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return roll(69);
			IDLE_BOTH:     return roll(16);
			default:       return 1'b0;
		endcase
	endfunction

	always @(negedge clk) out_stall <= receiver_stalls();

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_multi_point_spike_discriminator failed");
				$finish;
			end
		end
	end

	function automatic logic signed [mpsd_pkg::SAMPLE_W-1:0] small_noise();
		return mpsd_pkg::SAMPLE_W'(int'($urandom_range(0, 10000)) - 5000);
	endfunction

	function automatic logic signed [mpsd_pkg::SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 4))
				0:       return 16'sh7fff;
				1:       return 16'sh8000;
				2:       return '0;
				3:       return '1;
				default: return 16'sh0001;
			endcase
		end
		if (r < 70) return small_noise();
		return mpsd_pkg::SAMPLE_W'($urandom);
	endfunction

	function automatic mpsd_pkg::dot_t random_dot(input bit wide);
		mpsd_pkg::dot_t d;
		if (roll(10))
			d.threshold = roll(50) ? 16'sh7fff : 16'sh8000;
		else
			d.threshold = mpsd_pkg::SAMPLE_W'(int'($urandom_range(0, 8000)) - 4000);
		d.above = 1'($urandom_range(0, 1));
		d.offset = wide ? mpsd_pkg::OFFSET_W'($urandom) :
			mpsd_pkg::OFFSET_W'(int'($urandom_range(0, 8)) - 4);
		return d;
	endfunction

	// called just after a falling edge, returns just after one
	task automatic push_sample(input logic signed [mpsd_pkg::SAMPLE_W-1:0] value,
			input logic starts);
		while (sender_idles()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		first_sample <= starts;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [mpsd_pkg::INDEX_W-1:0] idx,
			input logic [mpsd_pkg::WORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_dots(input logic [mpsd_pkg::COUNT_W-1:0] count);
		count_now = count;
		write_reg(mpsd_pkg::REG_DOT_COUNT, mpsd_pkg::WORD_W'(count));
		for (int k = 0; k < mpsd_pkg::WORD_SLOTS; k++)
			write_reg(mpsd_pkg::INDEX_W'(mpsd_pkg::REG_DOT_WORD_0) + mpsd_pkg::INDEX_W'(k),
				dots_now[k]);
		if (roll(50))
			write_reg(mpsd_pkg::INDEX_W'(mpsd_pkg::REG_DOT_WORD_3) +
				mpsd_pkg::INDEX_W'($urandom_range(1, 3)), mpsd_pkg::WORD_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// holds the sender until every event is out and the pipeline is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// a window of samples laid out so that one position meets every active dot
	task automatic send_spike();
		int                                   active;
		int                                   early;
		int                                   late;
		int                                   level;
		logic signed [mpsd_pkg::SAMPLE_W-1:0] window [mpsd_pkg::AGE_LIMIT];
		active = (count_now > mpsd_pkg::WORD_SLOTS) ? mpsd_pkg::WORD_SLOTS : count_now;
		early = 0;
		late = 0;
		for (int j = 0; j < active; j++) begin
			if (int'(dots_now[j].offset) < early) early = int'(dots_now[j].offset);
			if (int'(dots_now[j].offset) > late) late = int'(dots_now[j].offset);
		end
		for (int i = 0; i <= late - early; i++)
			window[i] = mpsd_pkg::SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
		for (int j = 0; j < active; j++) begin
			level = int'(dots_now[j].threshold);
			if (dots_now[j].above) begin
				level += $urandom_range(1, 800);
				if (level > 32767) level = 32767;
			end else begin
				level -= $urandom_range(1, 800);
				if (level < -32768) level = -32768;
			end
			window[int'(dots_now[j].offset) - early] = mpsd_pkg::SAMPLE_W'(level);
		end
		for (int i = 0; i <= late - early; i++) push_sample(window[i], 1'b0);
	endtask

	initial begin
		logic [mpsd_pkg::COUNT_W-1:0] count;
		int                           start;
		int                           r;
		foreach (dots_now[k]) dots_now[k] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no dots: every position matches, so no event
		push_sample(16'sh7fff, 1'b1);
		push_sample(16'sh8000, 1'b0);
		push_sample('0, 1'b0);
		settle();

		// one dot above zero at offset zero, runs cut by new records
		dots_now[0] = '{offset: '0, above: 1'b1, threshold: '0};
		for (int k = 1; k < mpsd_pkg::WORD_SLOTS; k++) dots_now[k] = random_dot(1'b0);
		program_dots(mpsd_pkg::COUNT_W'(1));
		push_sample(16'sd100, 1'b1);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sd1, 1'b0);
		push_sample('0, 1'b0);
		push_sample(16'sd5, 1'b1);
		push_sample(16'sd7, 1'b1);
		push_sample('1, 1'b0);
		settle();

		// two dots on either side of the position, below and above
		dots_now[0] = '{offset: -6'sd1, above: 1'b1, threshold: '1};
		dots_now[1] = '{offset: 6'sd1, above: 1'b0, threshold: 16'sd1};
		program_dots(mpsd_pkg::COUNT_W'(2));
		push_sample('0, 1'b1);
		push_sample(16'sd3, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sd2, 1'b0);
		push_sample('1, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sd4, 1'b0);
		push_sample('0, 1'b0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			idle_mode = idle_mode_t'(p % 4);
			for (int k = 0; k < mpsd_pkg::WORD_SLOTS; k++) dots_now[k] = random_dot(roll(20));
			r = $urandom_range(0, 9);
			if (r == 0) count = '0;
			else if (r == 1) count = mpsd_pkg::COUNT_W'($urandom_range(5, 7));
			else count = mpsd_pkg::COUNT_W'($urandom_range(1, 4));
			if (p == 5) begin
				count = mpsd_pkg::COUNT_W'(4);
				dots_now[0].offset = -6'sd32;
				dots_now[1].offset = 6'sd31;
			end else if (p == 9) begin
				count = '1;
			end else if (p == 13) begin
				count = '0;
			end
			program_dots(count);

			start = sent;
			push_sample(pick_sample(), 1'($urandom_range(0, 1)));
			while (sent - start < PHASE_ITEMS) begin
				if (roll(30))
					send_spike();
				else
					push_sample(pick_sample(), $urandom_range(0, 149) == 0);
			end
			settle();
		end

		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb_multi_point_spike_discriminator passed");
		else
			$display("tb_multi_point_spike_discriminator failed");
		$finish;
	end

endmodule
